/* src/spbf_pkg.sv */
`timescale 1ns / 1ps

package spbf_pkg;

   localparam int unsigned RANGE_W     = 16;
   localparam int unsigned ANGLE_W     = 16;
   localparam int unsigned COORD_W     = 17;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned TRIG_W      = 15;
   localparam int unsigned PROD_MAG_W  = RANGE_W + TRIG_W;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 48;

   localparam logic [RANGE_W-1:0] NO_RETURN    = 16'hFFFF;
   localparam int unsigned        MAX_SCAN_SAMPLES = 4096;
   localparam logic [COUNT_W-1:0] HIT_CAP      =
      COUNT_W'((MAX_SCAN_SAMPLES < 8191) ? MAX_SCAN_SAMPLES : 8191);

   localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 16'd64;
   localparam logic [RANGE_W-1:0] HALF_WIDTH_RST  = 16'd2000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      REG_START_ANGLE  = 2'd0,
      REG_ANGLE_STEP   = 2'd1,
      REG_HALF_WIDTH_X = 2'd2,
      REG_HALF_WIDTH_Y = 2'd3
   } csr_index_type;

   // sine of a Q30 angle in radians, Taylor series to the x^13 term, unsigned Q0.15 result
   function automatic logic [TRIG_W-1:0] taylor_sine(input longint unsigned xq);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      x2   = (xq * xq) >> 30;
      term = xq;
      sum  = $signed(xq);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (($unsigned(sum) * 64'd32768) + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[TRIG_W-1:0];
   endfunction

endpackage

/* src/scan_polar_box_filter.sv */
`timescale 1ns / 1ps

// Each accepted transaction passes through one register stage for each of the sine ROM
// read, the multiply, and the round and box test.
// Throughput: one sample per cycle; any back-pressure on the result side stalls all stages.
// Samples that are neither a hit nor the last of a scan produce no result.
// Reset (synchronous, active high) restores register defaults, clears the hit count
// and the pipeline, and restarts the scan at the start angle.
module scan_polar_box_filter #(
   parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // range_mm [15:0]
   input  logic [spbf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x [16:0], point_y [33:17], hit_count [46:34], zero [47]
   output logic [spbf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spbf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spbf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spbf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import spbf_pkg::*;

   localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned FRAC_W = ANGLE_W - 2;
   localparam int unsigned SCL_W  = FRAC_W + IDX_W;

   logic [ANGLE_W-1:0] start_angle_ff;
   logic [ANGLE_W-1:0] angle_step_ff;
   logic [RANGE_W-1:0] half_width_x_ff;
   logic [RANGE_W-1:0] half_width_y_ff;
   logic               csr_write;
   csr_index_type      csr_index;

   logic [ANGLE_W-1:0] running_angle_ff, running_angle_in;
   logic               at_scan_start_ff, at_scan_start_in;
   logic [COUNT_W-1:0] scan_hits_ff, scan_hits_in;

   logic               advance;
   logic               accept;
   logic [ANGLE_W-1:0] beam_angle;
   logic [1:0]         quadrant;
   logic [SCL_W-1:0]   idx_scaled;
   logic [IDX_W-1:0]   idx_direct;
   logic [IDX_W-1:0]   idx_mirror;

   logic [TRIG_W-1:0]  sine_rom [0:SINE_TABLE_DEPTH];

   logic               valid_s1_ff;
   logic [RANGE_W-1:0] range_s1_ff;
   logic               last_s1_ff;
   logic [1:0]         quadrant_s1_ff;
   logic [TRIG_W-1:0]  tab_direct_s1_ff;
   logic [TRIG_W-1:0]  tab_mirror_s1_ff;
   logic [TRIG_W-1:0]  sin_mag_s1;
   logic [TRIG_W-1:0]  cos_mag_s1;

   logic                  valid_s2_ff;
   logic                  last_s2_ff;
   logic                  no_return_s2_ff;
   logic                  x_neg_s2_ff;
   logic                  y_neg_s2_ff;
   logic [PROD_MAG_W-1:0] x_prod_s2_ff;
   logic [PROD_MAG_W-1:0] y_prod_s2_ff;

   logic [PROD_MAG_W:0]   x_round;
   logic [PROD_MAG_W:0]   y_round;
   logic [COORD_W-1:0]    x_mag;
   logic [COORD_W-1:0]    y_mag;
   logic                  hit;
   logic                  emit;
   logic [COORD_W-1:0]    point_x;
   logic [COORD_W-1:0]    point_y;
   logic [COUNT_W-1:0]    count_now;

   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                  rsp_tuser_ff;
   logic                  rsp_tlast_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff  <= START_ANGLE_RST;
         angle_step_ff   <= ANGLE_STEP_RST;
         half_width_x_ff <= HALF_WIDTH_RST;
         half_width_y_ff <= HALF_WIDTH_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_START_ANGLE:  start_angle_ff  <= csr_pwdata[ANGLE_W-1:0];
            REG_ANGLE_STEP:   angle_step_ff   <= csr_pwdata[ANGLE_W-1:0];
            REG_HALF_WIDTH_X: half_width_x_ff <= csr_pwdata[RANGE_W-1:0];
            REG_HALF_WIDTH_Y: half_width_y_ff <= csr_pwdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_START_ANGLE:  csr_prdata = CSR_DATA_W'(start_angle_ff);
         REG_ANGLE_STEP:   csr_prdata = CSR_DATA_W'(angle_step_ff);
         REG_HALF_WIDTH_X: csr_prdata = CSR_DATA_W'(half_width_x_ff);
         REG_HALF_WIDTH_Y: csr_prdata = CSR_DATA_W'(half_width_y_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // quarter-wave sine ROM, entries fixed at elaboration
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam longint unsigned XQ = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
      assign sine_rom[k] = taylor_sine(XQ);
   end

   // handshake: the whole pipeline holds while a result waits
   assign advance    = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid & req_tready;

   // beam angle and table addresses
   assign beam_angle = at_scan_start_ff ? start_angle_ff : running_angle_ff;
   assign quadrant   = beam_angle[ANGLE_W-1:ANGLE_W-2];
   assign idx_scaled = SCL_W'(beam_angle[FRAC_W-1:0]) * SCL_W'(SINE_TABLE_DEPTH);
   assign idx_direct = idx_scaled[SCL_W-1:FRAC_W];
   assign idx_mirror = IDX_W'(SINE_TABLE_DEPTH) - idx_direct;

   always_comb begin
      running_angle_in = running_angle_ff;
      at_scan_start_in = at_scan_start_ff;
      if (accept) begin
         running_angle_in = beam_angle + angle_step_ff;
         at_scan_start_in = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_angle_ff <= '0;
         at_scan_start_ff <= 1'b1;
      end else begin
         running_angle_ff <= running_angle_in;
         at_scan_start_ff <= at_scan_start_in;
      end
   end

   // stage 1: ROM read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else if (advance) begin
         valid_s1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         range_s1_ff      <= req_tdata[RANGE_W-1:0];
         last_s1_ff       <= req_tlast;
         quadrant_s1_ff   <= quadrant;
         tab_direct_s1_ff <= sine_rom[idx_direct];
         tab_mirror_s1_ff <= sine_rom[idx_mirror];
      end
   end

   // cosine sits one quadrant ahead of sine
   assign sin_mag_s1 = quadrant_s1_ff[0] ? tab_mirror_s1_ff : tab_direct_s1_ff;
   assign cos_mag_s1 = quadrant_s1_ff[0] ? tab_direct_s1_ff : tab_mirror_s1_ff;

   // stage 2: magnitude products
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
      end else if (advance) begin
         valid_s2_ff <= valid_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_s2_ff      <= last_s1_ff;
         no_return_s2_ff <= (range_s1_ff == NO_RETURN);
         x_neg_s2_ff     <= quadrant_s1_ff[1] ^ quadrant_s1_ff[0];
         y_neg_s2_ff     <= quadrant_s1_ff[1];
         x_prod_s2_ff    <= PROD_MAG_W'(range_s1_ff) * PROD_MAG_W'(cos_mag_s1);
         y_prod_s2_ff    <= PROD_MAG_W'(range_s1_ff) * PROD_MAG_W'(sin_mag_s1);
      end
   end

   // round half away from zero, box test, hit count
   assign x_round = {1'b0, x_prod_s2_ff} + (PROD_MAG_W + 1)'(16384);
   assign y_round = {1'b0, y_prod_s2_ff} + (PROD_MAG_W + 1)'(16384);
   assign x_mag   = x_round[PROD_MAG_W:15];
   assign y_mag   = y_round[PROD_MAG_W:15];

   assign hit  = ~no_return_s2_ff
               & (x_mag < COORD_W'(half_width_x_ff))
               & (y_mag < COORD_W'(half_width_y_ff));
   assign emit = hit | last_s2_ff;

   assign point_x = ~hit ? '0 : (x_neg_s2_ff ? (~x_mag + 1'b1) : x_mag);
   assign point_y = ~hit ? '0 : (y_neg_s2_ff ? (~y_mag + 1'b1) : y_mag);

   assign count_now = (hit && (scan_hits_ff < HIT_CAP)) ? scan_hits_ff + 1'b1 : scan_hits_ff;

   always_comb begin
      scan_hits_in = scan_hits_ff;
      if (advance && valid_s2_ff) begin
         scan_hits_in = last_s2_ff ? '0 : count_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_hits_ff <= '0;
      end else begin
         scan_hits_ff <= scan_hits_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= valid_s2_ff & emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= {1'b0, count_now, point_y, point_x};
         rsp_tuser_ff <= hit;
         rsp_tlast_ff <= last_s2_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef ASSERT_OFF
   a_miss_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("non-hit result outside scan end");

   a_miss_zero_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[2*COORD_W-1:0] == '0))
      else $error("non-hit result carries a point");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      scan_hits_ff <= HIT_CAP)
      else $error("hit count beyond cap");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_s2_ff && last_s2_ff) |=> (scan_hits_ff == '0))
      else $error("hit count not cleared at scan end");
`endif

endmodule
